>>> src/assert_macros.svh
// Assertion macros shared by the edge store RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AMES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edge store check failed");

// Next-cycle implication, disabled while reset is asserted
`define AMES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edge store check failed");

`endif

>>> src/ames_pkg.sv
// Package for the adjacency matrix edge store: word types, opcodes, status codes.
// Depends on nothing; imported by the edge store top level.
package ames_pkg;

    // Field widths fixed by the interface
    localparam int OP_BITS     = 2;
    localparam int VTX_BITS    = 6;
    localparam int FIELD_BITS  = 16;
    localparam int STATUS_BITS = 2;

    // Configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 7;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX_COUNT    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNDIRECTED_MODE = 1'd1;

    // Defaults for the top level parameters
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_WEIGHT_BITS  = 16;
    localparam int DEF_DEGREE_BITS  = 16;

    // A self-loop moves its degree by this much
    localparam logic [1:0] LOOP_STEP = 2'd2;
    localparam logic [1:0] EDGE_STEP = 2'd1;

    // Opcodes
    localparam logic [OP_BITS-1:0] OP_ADD_EDGE    = 2'd0;
    localparam logic [OP_BITS-1:0] OP_REMOVE_EDGE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ_EDGE   = 2'd2;
    localparam logic [OP_BITS-1:0] OP_READ_DEGREE = 2'd3;

    // Status codes
    localparam logic [STATUS_BITS-1:0] STAT_OK          = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_RANGE       = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_ZERO_WEIGHT = 2'd2;

    // Command word
    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [VTX_BITS-1:0]   src_vertex;
        logic [VTX_BITS-1:0]   dst_vertex;
        logic [FIELD_BITS-1:0] edge_weight;
    } ames_cmd_t;

    // Result word
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [FIELD_BITS-1:0]  read_weight;
        logic [FIELD_BITS-1:0]  read_degree;
    } ames_res_t;

endpackage

>>> src/adjacency_matrix_edge_store.sv
// Adjacency matrix edge store over a weight matrix memory and a per-vertex degree memory.
// Depends on ames_pkg and assert_macros.svh.
// Done is registered from the lookup state for reads, errors and directed or loop
// updates, and from the destination update state for undirected non-loop add/remove.
// A new command is taken only in idle. Reset: asynchronous, active low; a clearing pass
// then zeroes every address of both memories while busy is high. Results cannot stall.
`include "assert_macros.svh"

module adjacency_matrix_edge_store #(
    parameter int MAX_VERTICES = ames_pkg::DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = ames_pkg::DEF_WEIGHT_BITS,
    parameter int DEGREE_BITS  = ames_pkg::DEF_DEGREE_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  ames_pkg::ames_cmd_t                   cmd,
    output logic                                  done,
    output ames_pkg::ames_res_t                   result,
    input  logic                                  cfg_write,
    input  logic [ames_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ames_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import ames_pkg::*;

    localparam int VBITS      = $clog2(MAX_VERTICES);
    localparam int ADDR_BITS  = 2 * VBITS;
    localparam int WMEM_DEPTH = 1 << ADDR_BITS;
    localparam int DMEM_DEPTH = 1 << VBITS;

    typedef enum logic [3:0] {
        ST_CLEAR      = 4'b0001,
        ST_IDLE       = 4'b0010,
        ST_LOOKUP     = 4'b0100,
        ST_UPDATE_DST = 4'b1000
    } state_t;

    // Saturating degree step
    function automatic logic [DEGREE_BITS-1:0] deg_adjust(
        input logic [DEGREE_BITS-1:0] deg,
        input logic                   up,
        input logic [1:0]             amt
    );
        logic [DEGREE_BITS:0] sum;
        sum = {1'b0, deg} + (DEGREE_BITS+1)'(amt);
        if (up)
            return sum[DEGREE_BITS] ? '1 : sum[DEGREE_BITS-1:0];
        else
            return (deg > DEGREE_BITS'(amt)) ? deg - DEGREE_BITS'(amt) : '0;
    endfunction

    // Control and configuration registers
    state_t                     state_reg, state_next;
    logic [ADDR_BITS-1:0]       clr_reg, clr_next;
    logic                       done_reg, done_next;
    logic [CFG_DATA_BITS-1:0]   vertex_count_reg;
    logic                       undirected_reg;

    // Command registers (payload)
    logic [OP_BITS-1:0]         op_reg;
    logic [VBITS-1:0]           s_idx_reg, d_idx_reg;
    logic [WEIGHT_BITS-1:0]     w_reg;
    logic [STATUS_BITS-1:0]     status_reg;
    ames_res_t                  res_reg, res_next;

    // Memories and their ports
    logic [WEIGHT_BITS-1:0]     wmem [WMEM_DEPTH];
    logic [DEGREE_BITS-1:0]     dmem [DMEM_DEPTH];
    logic                       w_we, w_re, d_we, d_re;
    logic [ADDR_BITS-1:0]       w_waddr, w_raddr;
    logic [VBITS-1:0]           d_waddr, d_raddr;
    logic [WEIGHT_BITS-1:0]     w_wdata, wrd_reg;
    logic [DEGREE_BITS-1:0]     d_wdata, drd_reg;

    // Decode of the incoming command
    logic                       accept;
    logic                       s_ok, d_ok;
    logic [VBITS-1:0]           s_in, d_in;
    logic [WEIGHT_BITS-1:0]     w_in;
    logic [STATUS_BITS-1:0]     status_in;

    // Decode of the held command
    logic                       is_loop, mutate, go_up;
    logic [WEIGHT_BITS-1:0]     new_w;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // Range and weight checks on the incoming word
    assign s_in = VBITS'(cmd.src_vertex);
    assign d_in = VBITS'(cmd.dst_vertex);
    assign w_in = WEIGHT_BITS'(cmd.edge_weight);
    assign s_ok = (32'(cmd.src_vertex) < 32'(vertex_count_reg))
               && (32'(cmd.src_vertex) < 32'(MAX_VERTICES));
    assign d_ok = (32'(cmd.dst_vertex) < 32'(vertex_count_reg))
               && (32'(cmd.dst_vertex) < 32'(MAX_VERTICES));

    always_comb
    begin
        if (cmd.op == OP_READ_DEGREE)
            status_in = s_ok ? STAT_OK : STAT_RANGE;
        else if (!s_ok || !d_ok)
            status_in = STAT_RANGE;
        else if (cmd.op == OP_ADD_EDGE && w_in == '0)
            status_in = STAT_ZERO_WEIGHT;
        else
            status_in = STAT_OK;
    end

    assign is_loop = (s_idx_reg == d_idx_reg);
    assign go_up   = (op_reg == OP_ADD_EDGE);
    assign mutate  = (status_reg == STAT_OK)
                  && (op_reg == OP_ADD_EDGE || op_reg == OP_REMOVE_EDGE);
    assign new_w   = go_up ? w_reg : '0;

    // Sequencer: memory port control and result build
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        w_we       = 1'b0;
        w_waddr    = {s_idx_reg, d_idx_reg};
        w_wdata    = new_w;
        w_re       = 1'b0;
        w_raddr    = {s_in, d_in};
        d_we       = 1'b0;
        d_waddr    = s_idx_reg;
        d_wdata    = deg_adjust(drd_reg, go_up, is_loop ? LOOP_STEP : EDGE_STEP);
        d_re       = 1'b0;
        d_raddr    = s_in;

        unique case (state_reg)
            ST_CLEAR:
            begin
                w_we     = 1'b1;
                w_waddr  = clr_reg;
                w_wdata  = '0;
                d_we     = 1'b1;
                d_waddr  = clr_reg[VBITS-1:0];
                d_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    w_re       = 1'b1;
                    d_re       = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (mutate)
                begin
                    w_we = 1'b1;
                    d_we = 1'b1;
                end
                if (mutate && undirected_reg && !is_loop)
                begin
                    // mirror entry and destination degree on the next pass
                    d_re       = 1'b1;
                    d_raddr    = d_idx_reg;
                    state_next = ST_UPDATE_DST;
                end
                else
                begin
                    done_next          = 1'b1;
                    res_next.status    = status_reg;
                    res_next.read_weight = (op_reg == OP_READ_EDGE && status_reg == STAT_OK)
                                         ? FIELD_BITS'(wrd_reg) : '0;
                    res_next.read_degree = (op_reg == OP_READ_DEGREE && status_reg == STAT_OK)
                                         ? FIELD_BITS'(drd_reg) : '0;
                    state_next         = ST_IDLE;
                end
            end
            ST_UPDATE_DST:
            begin
                w_we                 = 1'b1;
                w_waddr              = {d_idx_reg, s_idx_reg};
                d_we                 = 1'b1;
                d_waddr              = d_idx_reg;
                d_wdata              = deg_adjust(drd_reg, go_up, EDGE_STEP);
                done_next            = 1'b1;
                res_next.status      = STAT_OK;
                res_next.read_weight = '0;
                res_next.read_degree = '0;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
            undirected_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT:    vertex_count_reg <= cfg_data;
                CFG_UNDIRECTED_MODE: undirected_reg   <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Command capture and result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= cmd.op;
            s_idx_reg  <= s_in;
            d_idx_reg  <= d_in;
            w_reg      <= w_in;
            status_reg <= status_in;
        end
        res_reg <= res_next;
    end

    // Weight matrix memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (w_we)
            wmem[w_waddr] <= w_wdata;
        if (w_re)
            wrd_reg <= wmem[w_raddr];
    end

    // Degree memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (d_we)
            dmem[d_waddr] <= d_wdata;
        if (d_re)
            drd_reg <= dmem[d_raddr];
    end

    // Checks
    `AMES_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy)
    `AMES_ASSERT_NXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    `AMES_ASSERT_IMP(a_mirror_distinct, clk, rst_n, state_reg == ST_UPDATE_DST, s_idx_reg != d_idx_reg)
    `AMES_ASSERT_IMP(a_error_zero, clk, rst_n, done_reg && res_reg.status != STAT_OK, res_reg.read_weight == '0 && res_reg.read_degree == '0)

endmodule
